### hdl/ckq_pkg.sv
// ckq_pkg: shared types and constants of the chord key input qualifier
// no dependencies
`timescale 1ns / 1ps

package ckq_pkg;

  // widths fixed by the word format
  localparam int CHORD_W        = 5;
  localparam int SET_W          = 2;
  localparam int INDEX_W        = 7;
  localparam int CHAR_W         = 8;
  localparam int COUNT_W        = 16;
  localparam int MODE_W         = 2;
  localparam int CHORDS_PER_SET = 32;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAB_TIME    = 8'd0,
    CFG_QUALIFY_MODE = 8'd1
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // qualify mode bits
  localparam int MODE_IGNORE_RELEASE = 0;
  localparam int MODE_RESTART        = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] STAB_RESET = 16'd50;

  // configuration write towards the qualifier
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // settle event from the qualifier
  typedef struct packed {
    logic               emit;
    logic [CHORD_W-1:0] chord;
  } settle_t;

endpackage

### hdl/ckq_in_if.sv
// ckq_in_if, ckq_out_if, ckq_cfg_if: valid/ready channels of the qualifier
// depends on ckq_pkg
`timescale 1ns / 1ps

interface ckq_in_if import ckq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [CHORD_W-1:0] fingers;
  logic [SET_W-1:0]   char_set;
  logic [INDEX_W-1:0] table_index;
  logic [CHAR_W-1:0]  table_char;

  modport source (output valid, operation, fingers, char_set, table_index, table_char,
                  input ready);
  modport sink   (input valid, operation, fingers, char_set, table_index, table_char,
                  output ready);
endinterface

interface ckq_out_if import ckq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, character, input ready);
  modport sink   (input valid, character, output ready);
endinterface

interface ckq_cfg_if import ckq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/ckq_table.sv
// ckq_table: character table, one write and one registered read port
// per-entry valid bits give the cleared reset contents; depends on ckq_pkg
`timescale 1ns / 1ps

module ckq_table import ckq_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [CHAR_W-1:0] q_r;
  logic              q_vld_r;

  // storage and read register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // entry never written reads as zero
  assign rd_data = q_vld_r ? q_r : '0;

endmodule

### hdl/ckq_ctrl.sv
// ckq_ctrl: chord qualifier, configuration registers, wait counter, last chord
// depends on ckq_pkg
`timescale 1ns / 1ps

module ckq_ctrl import ckq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_wr_t            cfg_wr,
  input  logic               tick,
  input  logic [CHORD_W-1:0] fingers,
  output settle_t            settle
);

  logic [COUNT_W-1:0] stab_r;
  logic [MODE_W-1:0]  mode_r;
  logic [CHORD_W-1:0] last_r, last_nxt;
  logic               wait_r, wait_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               restart;

  assign restart = mode_r[MODE_RESTART];
  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stab_r <= STAB_RESET;
      mode_r <= '0;
    end else if (cfg_wr.we) begin
      if (cfg_wr.idx == CFG_STAB_TIME) begin
        stab_r <= cfg_wr.data;
      end else if (cfg_wr.idx == CFG_QUALIFY_MODE) begin
        mode_r <= cfg_wr.data[MODE_W-1:0];
      end
    end
  end

  // qualifier decision for one tick
  always_comb begin
    last_nxt     = last_r;
    wait_nxt     = wait_r;
    cnt_nxt      = cnt_r;
    settle.emit  = 1'b0;
    settle.chord = fingers;
    if (wait_r) begin
      if (restart) begin
        if (fingers != last_r) begin
          last_nxt = fingers;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
        if (cnt_nxt >= stab_r) begin
          wait_nxt     = 1'b0;
          settle.chord = last_nxt;
          settle.emit  = (last_nxt != '0);
        end
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_nxt >= stab_r) begin
          last_nxt    = fingers;
          wait_nxt    = 1'b0;
          settle.emit = (fingers != '0);
        end
      end
    end else if (fingers != last_r) begin
      priority if (fingers == '0) begin
        last_nxt = '0;
      end else if (mode_r[MODE_IGNORE_RELEASE] && (fingers < last_r)) begin
        last_nxt = fingers;
      end else begin
        cnt_nxt = '0;
        priority if (restart) begin
          last_nxt = fingers;
          wait_nxt = 1'b1;
        end else if (stab_r == '0) begin
          last_nxt    = fingers;
          settle.emit = 1'b1;
        end else begin
          wait_nxt = 1'b1;
        end
      end
    end
    if (!tick) begin
      settle.emit = 1'b0;
    end
  end

  // qualifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      wait_r <= 1'b0;
      cnt_r  <= '0;
    end else if (tick) begin
      last_r <= last_nxt;
      wait_r <= wait_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### hdl/chord_key_input_qualifier_core.sv
// chord_key_input_qualifier_core: top level, table lookup and output stages
// depends on ckq_pkg, the channel interfaces, ckq_ctrl and ckq_table
`timescale 1ns / 1ps

//  channel | modport | word
//  in_ch   | sink    | operation, fingers, char_set, table_index, table_char
//  out_ch  | source  | character
//  cfg_ch  | sink    | index, data (always ready)
//
//  One input word per cycle while in_ch is not stalled; a settled chord passes
//  through the registered table read and then the output register to out_ch.
//  Reset clears the qualifier state and the table valid bits and loads the
//  reset configuration at once, so no clearing pass is needed.
//  in_ch stalls only when a looked-up word sits in the read stage and the output
//  register is full and not taken.

module chord_key_input_qualifier_core import ckq_pkg::*; #(
  parameter int NUM_CHAR_SETS = 4
) (
  input  logic clk,
  input  logic rst_n,
  ckq_in_if.sink    in_ch,
  ckq_out_if.source out_ch,
  ckq_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = NUM_CHAR_SETS * CHORDS_PER_SET;
  localparam int AW    = $clog2(DEPTH);

  cfg_wr_t           cfg_wr;
  settle_t           settle;
  logic              in_acc;
  logic              tick;
  logic              wr_en;
  logic              rd_en;
  logic              set_ok;
  logic [31:0]       rd_addr_full;
  logic [CHAR_W-1:0] rd_data;
  logic              s1_valid_r;
  logic              s1_absent_r;
  logic              s1_move;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;

  // configuration port
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  // input handshake
  assign s1_move     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick        = in_acc && (in_ch.operation == OP_TICK);

  ckq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .tick    (tick),
    .fingers (in_ch.fingers),
    .settle  (settle)
  );

  // table addressing
  assign wr_en = in_acc && (in_ch.operation == OP_WRITE) &&
                 (int'(in_ch.table_index[INDEX_W-1:CHORD_W]) < NUM_CHAR_SETS);
  assign set_ok       = int'(in_ch.char_set) < NUM_CHAR_SETS;
  assign rd_addr_full = 32'(in_ch.char_set) * CHORDS_PER_SET + 32'(settle.chord);
  assign rd_en        = settle.emit;

  ckq_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_ch.table_index)),
    .wr_data (in_ch.table_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rd_en) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_absent_r <= !set_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_char_r <= s1_absent_r ? '0 : rd_data;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;

`ifndef SYNTHESIS
  // a looked-up word that cannot move stays in the read stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r)
    else $error("read stage word lost");

  // a lookup is only started when the read stage is free or draining
  a_rd_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (!s1_valid_r || s1_move))
    else $error("table read overwrote a pending word");

  // a word leaving the read stage lands in the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_move |=> out_valid_r)
    else $error("word dropped between read stage and output");
`endif

endmodule
